### design/tbgd_pkg.sv
// Shared types and constants of the two-button gesture decoder.
// Used by tbgd_button, two_button_gesture_decoder_core and the testbench; no dependencies.
`timescale 1ns / 1ps

package tbgd_pkg;

    localparam int unsigned TIME_W    = 32;
    localparam int unsigned WINDOW_W  = 16;
    localparam int unsigned MODE_W    = 5;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_W     = 32;
    localparam int unsigned CLICK_W   = 2;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_MODE           = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRACE          = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_A       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_B       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_FIRST_A = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_EVERY_A = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_FIRST_B = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_EVERY_B = 3'd7;

    // Mode flag bit positions
    localparam int unsigned MODE_BOTH_LONG = 0;
    localparam int unsigned MODE_DOUBLE_A  = 1;
    localparam int unsigned MODE_DOUBLE_B  = 2;
    localparam int unsigned MODE_REPEAT_A  = 3;
    localparam int unsigned MODE_REPEAT_B  = 4;

    // Reset values of the configuration registers
    localparam logic [MODE_W-1:0]   MODE_RST         = 5'd0;
    localparam logic [TIME_W-1:0]   GRACE_RST        = 32'd200;
    localparam logic [WINDOW_W-1:0] DOUBLE_RST       = 16'd300;
    localparam logic [TIME_W-1:0]   REPEAT_FIRST_RST = 32'd500;
    localparam logic [TIME_W-1:0]   REPEAT_EVERY_RST = 32'd100;

    typedef enum logic [3:0] {
        G_NONE      = 4'd0,
        G_SHORT_A   = 4'd1,
        G_SHORT_B   = 4'd2,
        G_DOUBLE_A  = 4'd3,
        G_DOUBLE_B  = 4'd4,
        G_LONG_A    = 4'd5,
        G_LONG_B    = 4'd6,
        G_REPEAT_A  = 4'd7,
        G_REPEAT_B  = 4'd8,
        G_BOTH_LONG = 4'd9
    } t_gesture;

    // Gesture kind decided by one button
    typedef enum logic [1:0] {
        K_NONE   = 2'd0,
        K_SHORT  = 2'd1,
        K_DOUBLE = 2'd2,
        K_LONG   = 2'd3
    } t_kind;

    typedef struct packed {
        logic                both_long_en;
        logic                double_en;
        logic                repeat_en;
        logic [TIME_W-1:0]   grace;
        logic [WINDOW_W-1:0] double_window;
        logic [TIME_W-1:0]   repeat_first;
        logic [TIME_W-1:0]   repeat_every;
    } t_btn_cfg;

    typedef struct packed {
        logic step;            // request accepted this cycle
        logic both_now;        // both buttons holding in this request
        logic both_prev;       // both were holding in the previous request
        logic rep_gate;        // repeat check is evaluated for this button
        logic clr_repeat;      // stop auto-repeat before evaluation
        logic cfg_clr_click;   // mode write changed the double-press enable
        logic cfg_clr_pending; // mode write has the two-button enable off
    } t_btn_ctl;

    typedef struct packed {
        logic hold_event;
        logic click_event;
        logic holding;
        logic other_down;
        logic other_holding;
    } t_btn_in;

endpackage

### design/tbgd_button.sv
// Per-button gesture state: click counting, deferred long and auto-repeat.
// Depends on tbgd_pkg.
`timescale 1ns / 1ps

module tbgd_button (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tbgd_pkg::t_btn_cfg          i_cfg,
    input  tbgd_pkg::t_btn_ctl          i_ctl,
    input  tbgd_pkg::t_btn_in           i_btn,
    input  logic [tbgd_pkg::TIME_W-1:0] i_now,
    output tbgd_pkg::t_kind             o_kind,
    output logic                        o_rep_due
);

    logic                         r_pending, n_pending;
    logic [tbgd_pkg::TIME_W-1:0]  r_deferred, n_deferred;
    logic [tbgd_pkg::CLICK_W-1:0] r_click, n_click;
    logic [tbgd_pkg::TIME_W-1:0]  r_first, n_first;
    logic [tbgd_pkg::TIME_W-1:0]  r_hold_start, n_hold_start;
    logic [tbgd_pkg::TIME_W-1:0]  r_last_rep, n_last_rep;

    logic [tbgd_pkg::CLICK_W-1:0] cc;
    logic [tbgd_pkg::TIME_W-1:0]  fc;
    logic [tbgd_pkg::TIME_W-1:0]  since_deferred;
    logic [tbgd_pkg::TIME_W-1:0]  since_first;
    logic [tbgd_pkg::TIME_W-1:0]  since_hold;
    logic [tbgd_pkg::TIME_W-1:0]  since_rep;
    tbgd_pkg::t_kind              kind;
    logic                         rep_due;

    assign since_deferred = i_now - r_deferred;

    always_comb begin
        n_pending    = r_pending;
        n_deferred   = r_deferred;
        n_click      = r_click;
        n_first      = r_first;
        n_last_rep   = r_last_rep;
        n_hold_start = i_ctl.clr_repeat ? '0 : r_hold_start;
        kind         = tbgd_pkg::K_NONE;
        rep_due      = 1'b0;
        cc           = r_click;
        fc           = r_first;
        since_first  = '0;
        since_hold   = '0;
        since_rep    = '0;

        if (i_ctl.both_now) begin
            if (!i_ctl.both_prev) begin
                n_click   = '0;
                n_pending = 1'b0;
            end
        end else begin
            // Leaving the both-held condition restarts the repeat clock
            if (i_ctl.both_prev && i_btn.holding) begin
                n_hold_start = i_now;
            end

            priority if (i_btn.hold_event) begin
                n_click = '0;
                if (i_cfg.both_long_en && i_btn.other_down && !i_btn.other_holding) begin
                    n_pending  = 1'b1;
                    n_deferred = i_now;
                end else begin
                    kind = tbgd_pkg::K_LONG;
                end
            end else if (r_pending && (since_deferred >= i_cfg.grace)) begin
                n_pending = 1'b0;
                kind      = tbgd_pkg::K_LONG;
            end else if (!i_cfg.double_en) begin
                kind = i_btn.click_event ? tbgd_pkg::K_SHORT : tbgd_pkg::K_NONE;
            end else begin
                if (i_btn.click_event) begin
                    if (cc == '0) begin
                        fc = i_now;
                    end
                    cc = cc + 1'b1;
                end
                since_first = i_now - fc;
                n_first     = fc;
                priority if (cc >= 2'd2) begin
                    n_click = '0;
                    kind    = tbgd_pkg::K_DOUBLE;
                end else if ((cc == 2'd1) &&
                             (since_first >= {{(tbgd_pkg::TIME_W-tbgd_pkg::WINDOW_W){1'b0}},
                                              i_cfg.double_window})) begin
                    n_click = '0;
                    kind    = tbgd_pkg::K_SHORT;
                end else begin
                    n_click = cc;
                end
            end

            if (kind == tbgd_pkg::K_LONG) begin
                n_hold_start = i_now;
            end

            // Auto-repeat; the state only moves when the check is reached
            since_hold = i_now - n_hold_start;
            since_rep  = i_now - r_last_rep;
            if (i_cfg.repeat_en) begin
                priority if (!i_btn.holding) begin
                    if (i_ctl.rep_gate) begin
                        n_last_rep = '0;
                    end
                end else if (n_hold_start == '0) begin
                    rep_due = 1'b0;
                end else if (r_last_rep == '0) begin
                    rep_due = (since_hold >= i_cfg.repeat_first);
                end else begin
                    rep_due = (since_rep >= i_cfg.repeat_every);
                end
                if (rep_due && i_ctl.rep_gate) begin
                    n_last_rep = i_now;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending    <= 1'b0;
            r_deferred   <= '0;
            r_click      <= '0;
            r_first      <= '0;
            r_hold_start <= '0;
            r_last_rep   <= '0;
        end else if (i_ctl.cfg_clr_click || i_ctl.cfg_clr_pending) begin
            if (i_ctl.cfg_clr_click) begin
                r_click <= '0;
            end
            if (i_ctl.cfg_clr_pending) begin
                r_pending <= 1'b0;
            end
        end else if (i_ctl.step) begin
            r_pending    <= n_pending;
            r_deferred   <= n_deferred;
            r_click      <= n_click;
            r_first      <= n_first;
            r_hold_start <= n_hold_start;
            r_last_rep   <= n_last_rep;
        end
    end

    assign o_kind    = kind;
    assign o_rep_due = rep_due;

endmodule

### design/two_button_gesture_decoder_core.sv
// Two-button gesture decoder: top level with configuration registers,
// both-held tracking, gesture arbitration and output register.
// Depends on tbgd_pkg and tbgd_button.
// Throughput: one request per cycle unless a result waits on i_out_ready. Results
// are registered: the per-button decision and the arbitration are a single pass
// of subtract-and-compare logic ahead of the output register.
// Reset (synchronous, active low): all gesture state cleared, registers at defaults.
`timescale 1ns / 1ps

module two_button_gesture_decoder_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write port
    input  logic                           i_cfg_we,
    input  logic [tbgd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tbgd_pkg::CFG_W-1:0]     i_cfg_data,
    // request channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [tbgd_pkg::TIME_W-1:0]    i_now_ms,
    input  logic                           i_a_press_edge,
    input  logic                           i_a_down,
    input  logic                           i_a_holding,
    input  logic                           i_a_hold_event,
    input  logic                           i_a_click_event,
    input  logic                           i_b_press_edge,
    input  logic                           i_b_down,
    input  logic                           i_b_holding,
    input  logic                           i_b_hold_event,
    input  logic                           i_b_click_event,
    input  logic [1:0]                     i_clear_repeat_mask,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [1:0]                     o_pressed_set,
    output logic [3:0]                     o_gesture_code
);

    // Configuration registers
    logic [tbgd_pkg::MODE_W-1:0]   r_mode;
    logic [tbgd_pkg::TIME_W-1:0]   r_grace;
    logic [tbgd_pkg::WINDOW_W-1:0] r_double_a, r_double_b;
    logic [tbgd_pkg::TIME_W-1:0]   r_rep_first_a, r_rep_every_a;
    logic [tbgd_pkg::TIME_W-1:0]   r_rep_first_b, r_rep_every_b;

    logic [tbgd_pkg::MODE_W-1:0]   mode_new;
    logic [tbgd_pkg::MODE_W-1:0]   mode_changed;
    logic                          mode_wr;

    // Request/result handshake and shared state
    logic                          accept;
    logic                          both_now;
    logic                          r_both_holding;
    logic                          r_out_valid;
    logic [1:0]                    r_pressed;
    tbgd_pkg::t_gesture            r_gesture, n_gesture;

    tbgd_pkg::t_btn_cfg            cfg_a, cfg_b;
    tbgd_pkg::t_btn_ctl            ctl_a, ctl_b;
    tbgd_pkg::t_btn_in             btn_a, btn_b;
    tbgd_pkg::t_kind               kind_a, kind_b;
    logic                          rep_due_a, rep_due_b;
    logic                          gate_a, gate_b;

    // Accept a new request whenever the output register is empty or being drained
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign both_now   = i_a_holding && i_b_holding;

    // A mode write clears the click count of a button whose double-press
    // enable flips, and drops both deferred longs when two-button long is off
    assign mode_wr      = i_cfg_we && (i_cfg_idx == tbgd_pkg::REG_MODE);
    assign mode_new     = i_cfg_data[tbgd_pkg::MODE_W-1:0];
    assign mode_changed = mode_new ^ r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= tbgd_pkg::MODE_RST;
            r_grace       <= tbgd_pkg::GRACE_RST;
            r_double_a    <= tbgd_pkg::DOUBLE_RST;
            r_double_b    <= tbgd_pkg::DOUBLE_RST;
            r_rep_first_a <= tbgd_pkg::REPEAT_FIRST_RST;
            r_rep_every_a <= tbgd_pkg::REPEAT_EVERY_RST;
            r_rep_first_b <= tbgd_pkg::REPEAT_FIRST_RST;
            r_rep_every_b <= tbgd_pkg::REPEAT_EVERY_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tbgd_pkg::REG_MODE:           r_mode        <= mode_new;
                tbgd_pkg::REG_GRACE:          r_grace       <= i_cfg_data;
                tbgd_pkg::REG_DOUBLE_A:       r_double_a    <= i_cfg_data[tbgd_pkg::WINDOW_W-1:0];
                tbgd_pkg::REG_DOUBLE_B:       r_double_b    <= i_cfg_data[tbgd_pkg::WINDOW_W-1:0];
                tbgd_pkg::REG_REPEAT_FIRST_A: r_rep_first_a <= i_cfg_data;
                tbgd_pkg::REG_REPEAT_EVERY_A: r_rep_every_a <= i_cfg_data;
                tbgd_pkg::REG_REPEAT_FIRST_B: r_rep_first_b <= i_cfg_data;
                tbgd_pkg::REG_REPEAT_EVERY_B: r_rep_every_b <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Per-button settings
    always_comb begin
        cfg_a.both_long_en  = r_mode[tbgd_pkg::MODE_BOTH_LONG];
        cfg_a.double_en     = r_mode[tbgd_pkg::MODE_DOUBLE_A];
        cfg_a.repeat_en     = r_mode[tbgd_pkg::MODE_REPEAT_A];
        cfg_a.grace         = r_grace;
        cfg_a.double_window = r_double_a;
        cfg_a.repeat_first  = r_rep_first_a;
        cfg_a.repeat_every  = r_rep_every_a;

        cfg_b.both_long_en  = r_mode[tbgd_pkg::MODE_BOTH_LONG];
        cfg_b.double_en     = r_mode[tbgd_pkg::MODE_DOUBLE_B];
        cfg_b.repeat_en     = r_mode[tbgd_pkg::MODE_REPEAT_B];
        cfg_b.grace         = r_grace;
        cfg_b.double_window = r_double_b;
        cfg_b.repeat_first  = r_rep_first_b;
        cfg_b.repeat_every  = r_rep_every_b;
    end

    // Button inputs, each seeing the other button's down and holding flags
    always_comb begin
        btn_a.hold_event    = i_a_hold_event;
        btn_a.click_event   = i_a_click_event;
        btn_a.holding       = i_a_holding;
        btn_a.other_down    = i_b_down;
        btn_a.other_holding = i_b_holding;

        btn_b.hold_event    = i_b_hold_event;
        btn_b.click_event   = i_b_click_event;
        btn_b.holding       = i_b_holding;
        btn_b.other_down    = i_a_down;
        btn_b.other_holding = i_a_holding;
    end

    // Repeat of A is checked only when no button made a gesture; repeat of B
    // only when A's repeat is not due either
    assign gate_a = (kind_a == tbgd_pkg::K_NONE) && (kind_b == tbgd_pkg::K_NONE);
    assign gate_b = gate_a && !rep_due_a;

    always_comb begin
        ctl_a.step            = accept;
        ctl_a.both_now        = both_now;
        ctl_a.both_prev       = r_both_holding;
        ctl_a.rep_gate        = gate_a;
        ctl_a.clr_repeat      = i_clear_repeat_mask[0];
        ctl_a.cfg_clr_click   = mode_wr && mode_changed[tbgd_pkg::MODE_DOUBLE_A];
        ctl_a.cfg_clr_pending = mode_wr && !mode_new[tbgd_pkg::MODE_BOTH_LONG];

        ctl_b.step            = accept;
        ctl_b.both_now        = both_now;
        ctl_b.both_prev       = r_both_holding;
        ctl_b.rep_gate        = gate_b;
        ctl_b.clr_repeat      = i_clear_repeat_mask[1];
        ctl_b.cfg_clr_click   = mode_wr && mode_changed[tbgd_pkg::MODE_DOUBLE_B];
        ctl_b.cfg_clr_pending = mode_wr && !mode_new[tbgd_pkg::MODE_BOTH_LONG];
    end

    tbgd_button u_btn_a (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg_a),
        .i_ctl     (ctl_a),
        .i_btn     (btn_a),
        .i_now     (i_now_ms),
        .o_kind    (kind_a),
        .o_rep_due (rep_due_a)
    );

    tbgd_button u_btn_b (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg_b),
        .i_ctl     (ctl_b),
        .i_btn     (btn_b),
        .i_now     (i_now_ms),
        .o_kind    (kind_b),
        .o_rep_due (rep_due_b)
    );

    // Arbitrate: both-held first, then A's gesture, then B's (dropped when A
    // has one), then A's repeat, then B's repeat
    always_comb begin
        n_gesture = tbgd_pkg::G_NONE;
        priority if (both_now) begin
            n_gesture = r_both_holding ? tbgd_pkg::G_NONE : tbgd_pkg::G_BOTH_LONG;
        end else if (kind_a != tbgd_pkg::K_NONE) begin
            unique case (kind_a)
                tbgd_pkg::K_SHORT:  n_gesture = tbgd_pkg::G_SHORT_A;
                tbgd_pkg::K_DOUBLE: n_gesture = tbgd_pkg::G_DOUBLE_A;
                tbgd_pkg::K_LONG:   n_gesture = tbgd_pkg::G_LONG_A;
                default:            n_gesture = tbgd_pkg::G_NONE;
            endcase
        end else if (kind_b != tbgd_pkg::K_NONE) begin
            unique case (kind_b)
                tbgd_pkg::K_SHORT:  n_gesture = tbgd_pkg::G_SHORT_B;
                tbgd_pkg::K_DOUBLE: n_gesture = tbgd_pkg::G_DOUBLE_B;
                tbgd_pkg::K_LONG:   n_gesture = tbgd_pkg::G_LONG_B;
                default:            n_gesture = tbgd_pkg::G_NONE;
            endcase
        end else if (rep_due_a) begin
            n_gesture = tbgd_pkg::G_REPEAT_A;
        end else if (rep_due_b) begin
            n_gesture = tbgd_pkg::G_REPEAT_B;
        end else begin
            n_gesture = tbgd_pkg::G_NONE;
        end
    end

    // Hold the both-held flag and the result valid flag; drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_both_holding <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (accept) begin
                r_both_holding <= both_now;
                r_out_valid    <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pressed <= {i_b_press_edge, i_a_press_edge};
            r_gesture <= n_gesture;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pressed_set  = r_pressed;
    assign o_gesture_code = r_gesture;

    // Every accepted request leaves a result in the output register
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_out_valid)
        else $error("accepted request produced no result");

    // A request with both buttons holding leaves the both-held flag set
    a_both_tracked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && both_now) |=> r_both_holding)
        else $error("both-held flag not set");

    // A both-long result is only produced on entering the both-held condition
    a_both_long_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && both_now && r_both_holding) |=> (o_gesture_code == tbgd_pkg::G_NONE))
        else $error("both-long repeated while still held");

endmodule

### test/tb_two_button_gesture_decoder_core.sv
// Testbench for two_button_gesture_decoder_core: directed polls, then random button traffic.
// Each result is checked against a pinned or predicted value; depends on tbgd_pkg and RTL.
`timescale 1ns / 1ps

module tb_two_button_gesture_decoder_core;

    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned SETTLE_CYCLES = 2;
    localparam int unsigned PHASES        = 8;
    localparam int unsigned PHASE_POLLS   = 56;

    // One button as seen in a poll: {press edge, down, holding, hold event, click event}
    localparam logic [4:0] F_IDLE    = 5'b00000;
    localparam logic [4:0] F_PRESS   = 5'b11000;
    localparam logic [4:0] F_DOWN    = 5'b01000;
    localparam logic [4:0] F_HOLD_EV = 5'b01110;
    localparam logic [4:0] F_HELD    = 5'b01100;
    localparam logic [4:0] F_CLICK   = 5'b00001;

    localparam logic FREE = 1'b0;
    localparam logic PIN  = 1'b1;

    typedef struct packed {
        logic [tbgd_pkg::TIME_W-1:0] now;
        logic                        a_edge;
        logic                        a_down;
        logic                        a_hold;
        logic                        a_hev;
        logic                        a_clk;
        logic                        b_edge;
        logic                        b_down;
        logic                        b_hold;
        logic                        b_hev;
        logic                        b_clk;
        logic [1:0]                  clr_mask;
    } t_poll;

    typedef struct packed {
        logic [1:0]         pressed;
        tbgd_pkg::t_gesture gesture;
    } t_result;

    // Directed row: either a register write or a poll, optionally with a typed-in result
    typedef struct {
        logic                           is_write;
        logic [tbgd_pkg::CFG_IDX_W-1:0] idx;
        logic [tbgd_pkg::CFG_W-1:0]     data;
        t_poll                          poll;
        logic                           pinned;
        t_result                        res;
    } t_row;

    typedef enum logic [1:0] {BTN_UP, BTN_DOWN, BTN_HELD} t_btn_state;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_we;
    logic [tbgd_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [tbgd_pkg::CFG_W-1:0]     cfg_data;
    logic                           req_valid;
    logic                           req_ready;
    t_poll                          poll_drv;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic [1:0]                     out_pressed;
    logic [3:0]                     out_gesture;

    // Typed-in result travels with the request it belongs to
    logic                           pin_on;
    t_result                        pin_res;

    t_result                        gesture_queue[$];
    t_row                           script[$];
    int unsigned                    err_count = 0;
    int unsigned                    cycle_count = 0;
    int unsigned                    ready_tick = 0;

    // Random traffic state
    t_btn_state                     btn_state[2] = '{BTN_UP, BTN_UP};
    logic [tbgd_pkg::TIME_W-1:0]    clock_ms = 32'd6000;

    // Predictor copy of the configuration
    logic [tbgd_pkg::MODE_W-1:0]    mode_bits;
    logic [tbgd_pkg::TIME_W-1:0]    grace_win;
    logic [tbgd_pkg::WINDOW_W-1:0]  dbl_win[2];
    logic [tbgd_pkg::TIME_W-1:0]    rep_first[2];
    logic [tbgd_pkg::TIME_W-1:0]    rep_every[2];

    // Predictor copy of the gesture state
    logic                           both_held;
    logic                           long_waiting[2];
    logic [tbgd_pkg::TIME_W-1:0]    long_defer_at[2];
    logic [tbgd_pkg::CLICK_W-1:0]   clicks[2];
    logic [tbgd_pkg::TIME_W-1:0]    click_at[2];
    logic [tbgd_pkg::TIME_W-1:0]    hold_at[2];
    logic [tbgd_pkg::TIME_W-1:0]    rep_at[2];

    always #10 clk = ~clk;

    two_button_gesture_decoder_core u_dut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_cfg_we            (cfg_we),
        .i_cfg_idx           (cfg_idx),
        .i_cfg_data          (cfg_data),
        .i_in_valid          (req_valid),
        .o_in_ready          (req_ready),
        .i_now_ms            (poll_drv.now),
        .i_a_press_edge      (poll_drv.a_edge),
        .i_a_down            (poll_drv.a_down),
        .i_a_holding         (poll_drv.a_hold),
        .i_a_hold_event      (poll_drv.a_hev),
        .i_a_click_event     (poll_drv.a_clk),
        .i_b_press_edge      (poll_drv.b_edge),
        .i_b_down            (poll_drv.b_down),
        .i_b_holding         (poll_drv.b_hold),
        .i_b_hold_event      (poll_drv.b_hev),
        .i_b_click_event     (poll_drv.b_clk),
        .i_clear_repeat_mask (poll_drv.clr_mask),
        .o_out_valid         (out_valid),
        .i_out_ready         (out_ready),
        .o_pressed_set       (out_pressed),
        .o_gesture_code      (out_gesture)
    );

    // ------------------------------------------------------------------
    // Gesture predictor
    // ------------------------------------------------------------------

    function automatic void clear_gesture_state();
        mode_bits = tbgd_pkg::MODE_RST;
        grace_win = tbgd_pkg::GRACE_RST;
        both_held = 1'b0;
        for (int b = 0; b < 2; b++) begin
            dbl_win[b]       = tbgd_pkg::DOUBLE_RST;
            rep_first[b]     = tbgd_pkg::REPEAT_FIRST_RST;
            rep_every[b]     = tbgd_pkg::REPEAT_EVERY_RST;
            long_waiting[b]  = 1'b0;
            long_defer_at[b] = '0;
            clicks[b]        = '0;
            click_at[b]      = '0;
            hold_at[b]       = '0;
            rep_at[b]        = '0;
        end
    endfunction

    function automatic void apply_reg_write(logic [tbgd_pkg::CFG_IDX_W-1:0] idx,
                                            logic [tbgd_pkg::CFG_W-1:0] data);
        logic [tbgd_pkg::MODE_W-1:0] nv;
        logic [tbgd_pkg::MODE_W-1:0] changed;
        case (idx)
            tbgd_pkg::REG_MODE: begin
                nv      = data[tbgd_pkg::MODE_W-1:0];
                changed = nv ^ mode_bits;
                // A flipped double-press enable forgets a half-counted double
                if (changed[tbgd_pkg::MODE_DOUBLE_A]) clicks[0] = '0;
                if (changed[tbgd_pkg::MODE_DOUBLE_B]) clicks[1] = '0;
                // Without two-button longs there is nothing to defer for
                if (!nv[tbgd_pkg::MODE_BOTH_LONG]) begin
                    long_waiting[0] = 1'b0;
                    long_waiting[1] = 1'b0;
                end
                mode_bits = nv;
            end
            tbgd_pkg::REG_GRACE:          grace_win    = data;
            tbgd_pkg::REG_DOUBLE_A:       dbl_win[0]   = data[tbgd_pkg::WINDOW_W-1:0];
            tbgd_pkg::REG_DOUBLE_B:       dbl_win[1]   = data[tbgd_pkg::WINDOW_W-1:0];
            tbgd_pkg::REG_REPEAT_FIRST_A: rep_first[0] = data;
            tbgd_pkg::REG_REPEAT_EVERY_A: rep_every[0] = data;
            tbgd_pkg::REG_REPEAT_FIRST_B: rep_first[1] = data;
            tbgd_pkg::REG_REPEAT_EVERY_B: rep_every[1] = data;
            default: ;
        endcase
    endfunction

    // Gesture decided by one button alone, before arbitration
    function automatic tbgd_pkg::t_gesture button_gesture(int b, logic hev, logic clk_ev,
                                                          logic odown, logic ohold,
                                                          logic [tbgd_pkg::TIME_W-1:0] now);
        tbgd_pkg::t_gesture          g_short;
        tbgd_pkg::t_gesture          g_double;
        tbgd_pkg::t_gesture          g_long;
        logic [tbgd_pkg::TIME_W-1:0] since;
        g_short  = b ? tbgd_pkg::G_SHORT_B : tbgd_pkg::G_SHORT_A;
        g_double = b ? tbgd_pkg::G_DOUBLE_B : tbgd_pkg::G_DOUBLE_A;
        g_long   = b ? tbgd_pkg::G_LONG_B : tbgd_pkg::G_LONG_A;

        if (hev) begin
            clicks[b] = '0;
            // Defer while the other button may still join as a two-button long
            if (mode_bits[tbgd_pkg::MODE_BOTH_LONG] && odown && !ohold) begin
                long_waiting[b]  = 1'b1;
                long_defer_at[b] = now;
                return tbgd_pkg::G_NONE;
            end
            return g_long;
        end

        since = now - long_defer_at[b];
        if (long_waiting[b] && since >= grace_win) begin
            long_waiting[b] = 1'b0;
            return g_long;
        end

        if (!mode_bits[tbgd_pkg::MODE_DOUBLE_A + b])
            return clk_ev ? g_short : tbgd_pkg::G_NONE;

        if (clk_ev) begin
            if (clicks[b] == '0)
                click_at[b] = now;
            clicks[b] = clicks[b] + 1'b1;
            if (clicks[b] >= 2) begin
                clicks[b] = '0;
                return g_double;
            end
        end

        // A lone click turns into a short once its window runs out
        since = now - click_at[b];
        if (clicks[b] == 1 && since >= {16'd0, dbl_win[b]}) begin
            clicks[b] = '0;
            return g_short;
        end
        return tbgd_pkg::G_NONE;
    endfunction

    function automatic logic repeat_fires(int b, logic holding,
                                          logic [tbgd_pkg::TIME_W-1:0] now);
        logic [tbgd_pkg::TIME_W-1:0] since;
        if (!mode_bits[tbgd_pkg::MODE_REPEAT_A + b])
            return 1'b0;
        if (!holding) begin
            rep_at[b] = '0;
            return 1'b0;
        end
        // Zero hold start means the repeat clock is stopped
        if (hold_at[b] == '0)
            return 1'b0;
        if (rep_at[b] == '0) begin
            since = now - hold_at[b];
            if (since >= rep_first[b]) begin
                rep_at[b] = now;
                return 1'b1;
            end
            return 1'b0;
        end
        since = now - rep_at[b];
        if (since >= rep_every[b]) begin
            rep_at[b] = now;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_result decode_poll(t_poll p);
        t_result            res;
        tbgd_pkg::t_gesture ga;
        tbgd_pkg::t_gesture gb;
        res.pressed = {p.b_edge, p.a_edge};
        res.gesture = tbgd_pkg::G_NONE;

        if (p.clr_mask[0]) hold_at[0] = '0;
        if (p.clr_mask[1]) hold_at[1] = '0;

        // Both holding: report once on entry, then stay quiet
        if (p.a_hold && p.b_hold) begin
            if (!both_held) begin
                both_held       = 1'b1;
                clicks[0]       = '0;
                clicks[1]       = '0;
                long_waiting[0] = 1'b0;
                long_waiting[1] = 1'b0;
                res.gesture     = tbgd_pkg::G_BOTH_LONG;
            end
            return res;
        end
        // Leaving both-held restarts the repeat clock of a button still held
        if (both_held) begin
            if (p.a_hold) hold_at[0] = p.now;
            if (p.b_hold) hold_at[1] = p.now;
        end
        both_held = 1'b0;

        ga = button_gesture(0, p.a_hev, p.a_clk, p.b_down, p.b_hold, p.now);
        gb = button_gesture(1, p.b_hev, p.b_clk, p.a_down, p.a_hold, p.now);
        if (ga == tbgd_pkg::G_LONG_A) hold_at[0] = p.now;
        if (gb == tbgd_pkg::G_LONG_B) hold_at[1] = p.now;

        // A wins over B; repeats only when neither button decided anything
        if (ga != tbgd_pkg::G_NONE)
            res.gesture = ga;
        else if (gb != tbgd_pkg::G_NONE)
            res.gesture = gb;
        else if (repeat_fires(0, p.a_hold, p.now))
            res.gesture = tbgd_pkg::G_REPEAT_A;
        else if (repeat_fires(1, p.b_hold, p.now))
            res.gesture = tbgd_pkg::G_REPEAT_B;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic void poll_row(logic [tbgd_pkg::TIME_W-1:0] now, logic [4:0] a,
                                     logic [4:0] b, logic [1:0] mask, logic pinned,
                                     logic [1:0] pressed, tbgd_pkg::t_gesture g);
        t_row r;
        r.is_write    = 1'b0;
        r.idx         = '0;
        r.data        = '0;
        r.poll        = {now, a, b, mask};
        r.pinned      = pinned;
        r.res.pressed = pressed;
        r.res.gesture = g;
        script.push_back(r);
    endfunction

    function automatic void write_row(logic [tbgd_pkg::CFG_IDX_W-1:0] idx,
                                      logic [tbgd_pkg::CFG_W-1:0] data);
        t_row r;
        r      = '{default: '0};
        r.is_write = 1'b1;
        r.idx  = idx;
        r.data = data;
        script.push_back(r);
    endfunction

    // Walk one button through up / down / held with random timing
    function automatic logic [4:0] next_button(int b);
        int         r;
        logic [4:0] f;
        r = $urandom_range(99);
        f = F_IDLE;
        case (btn_state[b])
            BTN_UP: begin
                if (r < 30) begin
                    f = F_PRESS;
                    btn_state[b] = BTN_DOWN;
                end
            end
            BTN_DOWN: begin
                if (r < 30) begin
                    f = F_CLICK;
                    btn_state[b] = BTN_UP;
                end else if (r < 55) begin
                    f = F_HOLD_EV;
                    btn_state[b] = BTN_HELD;
                end else begin
                    f = F_DOWN;
                end
            end
            default: begin
                // release from a hold is no click
                if (r < 12)
                    btn_state[b] = BTN_UP;
                else
                    f = F_HELD;
            end
        endcase
        return f;
    endfunction

    function automatic t_poll random_request();
        int                          r;
        logic [tbgd_pkg::TIME_W-1:0] advance;
        logic [1:0]                  mask;
        r = $urandom_range(99);
        // Noise: every flag combination, any time stamp
        if (r < 12)
            return {$urandom, 12'($urandom)};
        r = $urandom_range(99);
        if (r < 10)
            advance = '0;
        else if (r < 75)
            advance = $urandom_range(150, 1);
        else if (r < 95)
            advance = $urandom_range(900, 150);
        else
            advance = $urandom;
        clock_ms = clock_ms + advance;
        mask = ($urandom_range(99) < 8) ? 2'($urandom) : 2'b00;
        return {clock_ms, next_button(0), next_button(1), mask};
    endfunction

    // Present one request and hold it until the block takes it
    task automatic send_request(t_poll p, logic pinned, t_result pin);
        req_valid <= 1'b1;
        poll_drv  <= p;
        pin_on    <= pinned;
        pin_res   <= pin;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
    endtask

    // Write a register only once every result is home
    task automatic write_reg(logic [tbgd_pkg::CFG_IDX_W-1:0] idx,
                             logic [tbgd_pkg::CFG_W-1:0] data);
        req_valid <= 1'b0;
        @(posedge clk);
        while (gesture_queue.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        err_count++;
    endtask

    // ------------------------------------------------------------------
    // Result side: stall on a pattern picked by a running count of clock cycles
    // ------------------------------------------------------------------

    always @(posedge clk) begin
        ready_tick = ready_tick + 1;
        case (ready_tick[9:7])
            3'd0, 3'd1: out_ready <= 1'b1;
            3'd2:       out_ready <= ($urandom_range(99) < 60);
            3'd3:       out_ready <= (ready_tick[2:0] != 3'd0);
            3'd4:       out_ready <= ready_tick[3];
            default:    out_ready <= ($urandom_range(99) < 85);
        endcase
    end

    // ------------------------------------------------------------------
    // Monitor: check results in order, mirror writes, predict accepted requests
    // ------------------------------------------------------------------

    always @(posedge clk) begin : monitor
        t_result want;
        if (!rst_n) begin
            clear_gesture_state();
        end else begin
            if (out_valid && out_ready) begin
                if (gesture_queue.size() == 0) begin
                    report_mismatch($sformatf("result with nothing pending: set %0d gesture %0d",
                                              out_pressed, out_gesture));
                end else begin
                    want = gesture_queue.pop_front();
                    if (out_pressed !== want.pressed)
                        report_mismatch($sformatf("pressed set %0d, expected %0d",
                                                  out_pressed, want.pressed));
                    if (out_gesture !== want.gesture)
                        report_mismatch($sformatf("gesture %0d, expected %0d",
                                                  out_gesture, want.gesture));
                end
            end
            if (cfg_we)
                apply_reg_write(cfg_idx, cfg_data);
            if (req_valid && req_ready) begin
                // run the predictor even for typed-in rows to keep its state current
                want = decode_poll(poll_drv);
                gesture_queue.push_back(pin_on ? pin_res : want);
            end
        end
    end

    // Hard stop if the run hangs
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_two_button_gesture_decoder_core: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial begin : stimulus
        logic [tbgd_pkg::CFG_W-1:0] cfg_val[8];
        int                         burst_left;
        int                         gap;
        int                         gap_max;

        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_idx   <= '0;
        cfg_data  <= '0;
        req_valid <= 1'b0;
        poll_drv  <= '0;
        pin_on    <= 1'b0;
        pin_res   <= '0;

        // Defaults after reset: no double, no repeat, no two-button deferral
        poll_row(32'd0,    F_IDLE,    F_IDLE,    2'b00, PIN,  2'd0, tbgd_pkg::G_NONE);
        poll_row(32'd10,   F_PRESS,   F_IDLE,    2'b00, PIN,  2'd1, tbgd_pkg::G_NONE);
        poll_row(32'd100,  F_CLICK,   F_IDLE,    2'b00, PIN,  2'd0, tbgd_pkg::G_SHORT_A);
        poll_row(32'd120,  F_IDLE,    F_PRESS,   2'b00, PIN,  2'd2, tbgd_pkg::G_NONE);
        poll_row(32'd130,  F_IDLE,    F_CLICK,   2'b00, PIN,  2'd0, tbgd_pkg::G_SHORT_B);
        poll_row(32'd140,  F_PRESS,   F_PRESS,   2'b00, PIN,  2'd3, tbgd_pkg::G_NONE);
        poll_row(32'd700,  F_HOLD_EV, F_DOWN,    2'b00, PIN,  2'd0, tbgd_pkg::G_LONG_A);
        poll_row(32'd720,  F_HELD,    F_HOLD_EV, 2'b00, PIN,  2'd0, tbgd_pkg::G_BOTH_LONG);
        poll_row(32'd800,  F_HELD,    F_HELD,    2'b00, PIN,  2'd0, tbgd_pkg::G_NONE);
        // leave both-held with B still down
        poll_row(32'd900,  F_IDLE,    F_HELD,    2'b00, FREE, 2'd0, tbgd_pkg::G_NONE);
        // every mode bit on; upper data bits must be dropped
        write_row(tbgd_pkg::REG_MODE, 32'hFFFF_FFFF);
        poll_row(32'd1000, F_CLICK,   F_IDLE,    2'b00, FREE, 2'd0, tbgd_pkg::G_NONE);
        poll_row(32'd1100, F_CLICK,   F_IDLE,    2'b00, FREE, 2'd0, tbgd_pkg::G_NONE);
        poll_row(32'd1200, F_IDLE,    F_CLICK,   2'b00, FREE, 2'd0, tbgd_pkg::G_NONE);
        poll_row(32'd1600, F_IDLE,    F_IDLE,    2'b00, FREE, 2'd0, tbgd_pkg::G_NONE);
        // deferred long absorbed by a two-button long
        poll_row(32'd2000, F_PRESS,   F_PRESS,   2'b00, FREE, 2'd0, tbgd_pkg::G_NONE);
        poll_row(32'd2100, F_HOLD_EV, F_DOWN,    2'b00, FREE, 2'd0, tbgd_pkg::G_NONE);
        poll_row(32'd2150, F_HELD,    F_HOLD_EV, 2'b00, FREE, 2'd0, tbgd_pkg::G_NONE);
        // deferred long released by the grace window, then repeats
        poll_row(32'd3000, F_PRESS,   F_PRESS,   2'b00, FREE, 2'd0, tbgd_pkg::G_NONE);
        poll_row(32'd3100, F_HOLD_EV, F_DOWN,    2'b00, FREE, 2'd0, tbgd_pkg::G_NONE);
        poll_row(32'd3400, F_HELD,    F_DOWN,    2'b00, FREE, 2'd0, tbgd_pkg::G_NONE);
        poll_row(32'd3900, F_HELD,    F_IDLE,    2'b00, FREE, 2'd0, tbgd_pkg::G_NONE);
        poll_row(32'd4000, F_HELD,    F_IDLE,    2'b00, FREE, 2'd0, tbgd_pkg::G_NONE);
        poll_row(32'd4050, F_HELD,    F_IDLE,    2'b11, FREE, 2'd0, tbgd_pkg::G_NONE);
        // a long at time zero leaves the repeat clock stopped
        poll_row(32'd0,    F_IDLE,    F_PRESS,   2'b00, FREE, 2'd0, tbgd_pkg::G_NONE);
        poll_row(32'd0,    F_IDLE,    F_HOLD_EV, 2'b00, FREE, 2'd0, tbgd_pkg::G_NONE);
        write_row(tbgd_pkg::REG_REPEAT_FIRST_B, 32'd0);
        poll_row(32'd5,    F_IDLE,    F_HELD,    2'b00, FREE, 2'd0, tbgd_pkg::G_NONE);
        poll_row(32'd5000, F_IDLE,    F_PRESS,   2'b00, FREE, 2'd0, tbgd_pkg::G_NONE);
        poll_row(32'd5100, F_IDLE,    F_HOLD_EV, 2'b00, FREE, 2'd0, tbgd_pkg::G_NONE);
        poll_row(32'd5101, F_IDLE,    F_HELD,    2'b00, FREE, 2'd0, tbgd_pkg::G_NONE);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[k]) begin
            if (script[k].is_write)
                write_reg(script[k].idx, script[k].data);
            else
                send_request(script[k].poll, script[k].pinned, script[k].res);
        end

        // Random phases, each under its own settings
        burst_left = 0;
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    // lower extremes of every timing register
                    cfg_val[tbgd_pkg::REG_MODE]           = 32'd31;
                    cfg_val[tbgd_pkg::REG_GRACE]          = 32'd0;
                    cfg_val[tbgd_pkg::REG_DOUBLE_A]       = 32'd0;
                    cfg_val[tbgd_pkg::REG_DOUBLE_B]       = 32'd0;
                    cfg_val[tbgd_pkg::REG_REPEAT_FIRST_A] = 32'd0;
                    cfg_val[tbgd_pkg::REG_REPEAT_EVERY_A] = 32'd0;
                    cfg_val[tbgd_pkg::REG_REPEAT_FIRST_B] = 32'd0;
                    cfg_val[tbgd_pkg::REG_REPEAT_EVERY_B] = 32'd0;
                end
                1: begin
                    // upper extremes
                    cfg_val[tbgd_pkg::REG_MODE]           = 32'hFFFF_FFFF;
                    cfg_val[tbgd_pkg::REG_GRACE]          = 32'hFFFF_FFFF;
                    cfg_val[tbgd_pkg::REG_DOUBLE_A]       = 32'hFFFF_FFFF;
                    cfg_val[tbgd_pkg::REG_DOUBLE_B]       = 32'hFFFF_FFFF;
                    cfg_val[tbgd_pkg::REG_REPEAT_FIRST_A] = 32'hFFFF_FFFF;
                    cfg_val[tbgd_pkg::REG_REPEAT_EVERY_A] = 32'hFFFF_FFFF;
                    cfg_val[tbgd_pkg::REG_REPEAT_FIRST_B] = 32'hFFFF_FFFF;
                    cfg_val[tbgd_pkg::REG_REPEAT_EVERY_B] = 32'hFFFF_FFFF;
                end
                default: begin
                    cfg_val[tbgd_pkg::REG_MODE]           = (ph == 2) ? 32'd0 : $urandom;
                    cfg_val[tbgd_pkg::REG_GRACE]          = $urandom_range(600, 0);
                    cfg_val[tbgd_pkg::REG_DOUBLE_A]       = ($urandom & 32'hFFFF_0000) |
                                                            $urandom_range(500, 0);
                    cfg_val[tbgd_pkg::REG_DOUBLE_B]       = ($urandom & 32'hFFFF_0000) |
                                                            $urandom_range(500, 0);
                    cfg_val[tbgd_pkg::REG_REPEAT_FIRST_A] = $urandom_range(800, 0);
                    cfg_val[tbgd_pkg::REG_REPEAT_EVERY_A] = $urandom_range(300, 0);
                    cfg_val[tbgd_pkg::REG_REPEAT_FIRST_B] = $urandom_range(800, 0);
                    cfg_val[tbgd_pkg::REG_REPEAT_EVERY_B] = $urandom_range(300, 0);
                end
            endcase
            for (int i = 0; i < 8; i++)
                write_reg(tbgd_pkg::CFG_IDX_W'(i), cfg_val[i]);

            // run the clock across the 32-bit wrap in one phase
            if (ph == 3)
                clock_ms = 32'hFFFF_FC00;
            // one phase sends back to back
            gap_max = (ph == 2) ? 0 : 6;

            for (int n = 0; n < PHASE_POLLS; n++) begin
                if (burst_left == 0) begin
                    gap = (gap_max == 0) ? 0 : $urandom_range(gap_max, 0);
                    if (gap > 0) begin
                        req_valid <= 1'b0;
                        repeat (gap) @(posedge clk);
                    end
                    burst_left = ($urandom_range(99) < 20) ? $urandom_range(40, 13)
                                                            : $urandom_range(12, 1);
                end
                send_request(random_request(), FREE, '0);
                burst_left--;
            end
        end

        // Drain: let the last prediction land, then wait out every result
        req_valid <= 1'b0;
        @(posedge clk);
        while (gesture_queue.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        if (err_count == 0)
            $display("tb_two_button_gesture_decoder_core: clean");
        else
            $display("tb_two_button_gesture_decoder_core: errors");
        $finish;
    end

endmodule

### files.f
design/tbgd_pkg.sv
design/tbgd_button.sv
design/two_button_gesture_decoder_core.sv
test/tb_two_button_gesture_decoder_core.sv
